// ===== sv/pdbc_pkg.sv =====
package pdbc_pkg;

  // frame and fixed-point sizes
  localparam int unsigned FRAME_BITS     = 8;
  localparam int unsigned DUTY_FRAC_BITS = 16;

  // field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned RIDX_W = 3;
  localparam int unsigned FREQ_W = 20;
  localparam int unsigned DUTY_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // stream word widths, padded to whole bytes
  localparam int unsigned IN_FIELDS_W  = TIME_W + RIDX_W + 1;
  localparam int unsigned IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = FREQ_W + DUTY_W + 3 + DUTY_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // frame store sizing
  localparam int unsigned CNT_W   = $clog2(FRAME_BITS + 1);
  localparam int unsigned STORE_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;

  // serial divider sizing
  localparam int unsigned DIV_W  = (FREQ_W > DUTY_FRAC_BITS) ? FREQ_W : DUTY_FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(DIV_W);

  // constants
  localparam logic [FREQ_W-1:0] MICRO_PER_SEC = FREQ_W'(1000000);
  localparam logic [DUTY_W-1:0] DUTY_MAX =
    (DUTY_FRAC_BITS >= DUTY_W) ? {DUTY_W{1'b1}} : DUTY_W'((1 << DUTY_FRAC_BITS) - 1);

  // item kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_RISE = 2'd0,
    MODE_FALL = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQ_LOW  = 1'b0,
    REG_FREQ_HIGH = 1'b1
  } reg_e;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_THR  = 5'b00010,
    S_FDIV = 5'b00100,
    S_DDIV = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

endpackage

// ===== sv/pulse_duty_bit_capture.sv =====
// falling edge: threshold, frequency and duty division and finish states, then the output
//   register; the next word is taken only back in idle; a bit-serial restoring divider gives
//   one quotient bit per cycle, 20 bits for the frequency then DUTY_FRAC_BITS bits for the duty
// rising edge, host read and unused kinds: straight to the finish state, then the output register
// one output register lets the next input word in while a result waits
// asynchronous reset clears timestamps, store, count and ready flag; band limits 0 and 1000000
module pulse_duty_bit_capture (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pdbc_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // time_us, read_index, clear_ready
  input  logic [pdbc_pkg::MODE_W-1:0]      s_axis_tuser,  // mode
  // result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pdbc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // frequency_hz, duty_q16, in_band,
                                                          // captured, frame_ready, read_duty_q16
  // register writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pdbc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pdbc_pkg::FREQ_W-1:0]      cfg_data_i
);
  import pdbc_pkg::*;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [RIDX_W-1:0]   idx_q, idx_d;
  logic                clr_q, clr_d;
  logic [TIME_W-1:0]   last_fall_q, last_fall_d;
  logic [TIME_W-1:0]   last_rise_q, last_rise_d;
  logic [TIME_W-1:0]   period_q, period_d;
  logic [TIME_W-1:0]   high_q, high_d;
  logic [TIME_W+2:0]   h5_q, h5_d;
  logic [TIME_W+2:0]   p3_q, p3_d;
  logic                pzero_q, pzero_d;
  logic                hge_q, hge_d;
  logic [TIME_W-1:0]   rem_q, rem_d;
  logic [FREQ_W-1:0]   num_q, num_d;
  logic [DIV_W-1:0]    quo_q, quo_d;
  logic [STEP_W-1:0]   cnt_q, cnt_d;
  logic [FREQ_W-1:0]   freq_q, freq_d;
  logic [DUTY_W-1:0]   duty_q, duty_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ready_q, ready_d;
  logic [DUTY_W-1:0]   store_q [FRAME_BITS];
  logic [DUTY_W-1:0]   store_d [FRAME_BITS];
  logic [FREQ_W-1:0]   freq_low_q, freq_low_d;
  logic [FREQ_W-1:0]   freq_high_q, freq_high_d;
  logic                out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // input word fields
  logic [TIME_W-1:0]   in_time;
  logic [RIDX_W-1:0]   in_idx;
  logic                in_clr;
  logic                in_fire;

  // divider step
  logic [TIME_W:0]     div_r2;
  logic [TIME_W+1:0]   div_diff;
  logic                div_ge;
  logic [TIME_W-1:0]   rem_step;
  logic [DIV_W-1:0]    quo_step;

  // finishing values
  logic                out_room;
  logic [FREQ_W-1:0]   freq_v;
  logic [DUTY_W-1:0]   duty_v;
  logic                outside;
  logic                band;
  logic [DUTY_W-1:0]   rd_v;
  logic                res_fall;
  logic                res_cap;
  logic                res_rdy;

  assign in_time = s_axis_tdata[TIME_W-1:0];
  assign in_idx  = s_axis_tdata[TIME_W+RIDX_W-1:TIME_W];
  assign in_clr  = s_axis_tdata[TIME_W+RIDX_W];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // one restoring division step, next numerator bit shifted in
  assign div_r2   = {rem_q, num_q[FREQ_W-1]};
  assign div_diff = {1'b0, div_r2} - {2'b00, period_q};
  assign div_ge   = ~div_diff[TIME_W+1];
  assign rem_step = div_ge ? div_diff[TIME_W-1:0] : div_r2[TIME_W-1:0];
  assign quo_step = {quo_q[DIV_W-2:0], div_ge};

  // saturation, duty thresholds on the exact ratio, frequency band
  assign out_room = !out_valid_q || m_axis_tready;
  assign freq_v   = pzero_q ? MICRO_PER_SEC : freq_q;
  assign duty_v   = (pzero_q || hge_q) ? DUTY_MAX : duty_q;
  assign outside  = pzero_q || (h5_q > p3_q) || (h5_q < {2'b00, period_q, 1'b0});
  assign band     = (freq_v > freq_low_q) && (freq_v < freq_high_q);

  // stored duty selected by a host read
  always_comb begin
    rd_v = '0;
    for (int i = 0; i < FRAME_BITS; i++) begin
      if (RIDX_W'(i) == idx_q && i < (1 << RIDX_W)) begin
        rd_v = store_q[i];
      end
    end
  end

  // sequencer, divider and frame bookkeeping
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    clr_d       = clr_q;
    last_fall_d = last_fall_q;
    last_rise_d = last_rise_q;
    period_d    = period_q;
    high_d      = high_q;
    h5_d        = h5_q;
    p3_d        = p3_q;
    pzero_d     = pzero_q;
    hge_d       = hge_q;
    rem_d       = rem_q;
    num_d       = num_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    freq_d      = freq_q;
    duty_d      = duty_q;
    count_d     = count_q;
    ready_d     = ready_q;
    store_d     = store_q;
    freq_low_d  = freq_low_q;
    freq_high_d = freq_high_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    res_fall    = 1'b0;
    res_cap     = 1'b0;
    res_rdy     = ready_q;

    // register writes
    if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_FREQ_LOW:  freq_low_d  = cfg_data_i;
        REG_FREQ_HIGH: freq_high_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_d   = mode_e'(s_axis_tuser);
          idx_d    = in_idx;
          clr_d    = in_clr;
          period_d = in_time - last_fall_q;
          high_d   = in_time - last_rise_q;
          state_d  = S_FIN;
          case (mode_e'(s_axis_tuser))
            MODE_RISE: last_rise_d = in_time;
            MODE_FALL: begin
              last_fall_d = in_time;
              state_d     = S_THR;
            end
            MODE_READ: ;
            MODE_NONE: ;
            default: ;
          endcase
        end
      end
      S_THR: begin
        h5_d    = {1'b0, high_q, 2'b00} + {3'b000, high_q};
        p3_d    = {2'b00, period_q, 1'b0} + {3'b000, period_q};
        pzero_d = (period_q == '0);
        hge_d   = (high_q >= period_q);
        rem_d   = '0;
        num_d   = MICRO_PER_SEC;
        quo_d   = '0;
        cnt_d   = STEP_W'(FREQ_W - 1);
        state_d = S_FDIV;
      end
      S_FDIV: begin
        rem_d = rem_step;
        num_d = {num_q[FREQ_W-2:0], 1'b0};
        quo_d = quo_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          freq_d  = quo_step[FREQ_W-1:0];
          rem_d   = high_q;
          num_d   = '0;
          quo_d   = '0;
          cnt_d   = STEP_W'(DUTY_FRAC_BITS - 1);
          state_d = S_DDIV;
        end
      end
      S_DDIV: begin
        rem_d = rem_step;
        num_d = {num_q[FREQ_W-2:0], 1'b0};
        quo_d = quo_step;
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          duty_d  = quo_step[DUTY_W-1:0];
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_room) begin
          res_fall = (mode_q == MODE_FALL);
          // frame capture on a measured falling edge
          if (res_fall && !ready_q) begin
            if (band) begin
              if (outside && count_q < CNT_W'(FRAME_BITS)) begin
                store_d[count_q[STORE_W-1:0]] = duty_v;
                count_d = count_q + 1'b1;
                res_cap = 1'b1;
              end
            end else begin
              if (count_q >= CNT_W'(FRAME_BITS)) begin
                ready_d = 1'b1;
              end
              count_d = '0;
            end
          end
          res_rdy = ready_d;
          if (mode_q == MODE_READ && clr_q) begin
            ready_d = 1'b0;
          end
          out_valid_d = 1'b1;
          out_data_d  = OUT_DATA_W'({
            (mode_q == MODE_READ) ? rd_v : {DUTY_W{1'b0}},
            res_rdy,
            res_cap,
            res_fall && band,
            res_fall ? duty_v : {DUTY_W{1'b0}},
            res_fall ? freq_v : {FREQ_W{1'b0}}
          });
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state and stored history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_fall_q <= '0;
      last_rise_q <= '0;
      count_q     <= '0;
      ready_q     <= 1'b0;
      freq_low_q  <= '0;
      freq_high_q <= MICRO_PER_SEC;
      out_valid_q <= 1'b0;
      for (int i = 0; i < FRAME_BITS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      last_fall_q <= last_fall_d;
      last_rise_q <= last_rise_d;
      count_q     <= count_d;
      ready_q     <= ready_d;
      freq_low_q  <= freq_low_d;
      freq_high_q <= freq_high_d;
      out_valid_q <= out_valid_d;
      store_q     <= store_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    idx_q      <= idx_d;
    clr_q      <= clr_d;
    period_q   <= period_d;
    high_q     <= high_d;
    h5_q       <= h5_d;
    p3_q       <= p3_d;
    pzero_q    <= pzero_d;
    hge_q      <= hge_d;
    rem_q      <= rem_d;
    num_q      <= num_d;
    quo_q      <= quo_d;
    cnt_q      <= cnt_d;
    freq_q     <= freq_d;
    duty_q     <= duty_d;
    out_data_q <= out_data_d;
  end

  // fill count never passes the frame size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FRAME_BITS))
    else $error("frame count overflow");

  // ready flag only rises when a falling edge finishes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ready_q) |-> $past(state_q == S_FIN && mode_q == MODE_FALL))
    else $error("ready flag set outside a falling edge");

  // a captured duty is always in band and leaves no frame ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[FREQ_W+DUTY_W+1]) |->
      (out_data_q[FREQ_W+DUTY_W] && !out_data_q[FREQ_W+DUTY_W+2]))
    else $error("capture without band or with frame ready");

  // duty division keeps its partial remainder below the period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DDIV && !hge_q) |-> (rem_q < period_q))
    else $error("duty remainder out of range");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import pdbc_pkg::*;

  // run limits and receiver hold-off
  localparam int unsigned SETTLE_CYCLES = 45;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned TIMEOUT_UNITS = 1000000;
  localparam int unsigned PHASE_ITEMS   = 150;

  // one result word, unpacked
  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [DUTY_W-1:0] duty;
    logic              band;
    logic              cap;
    logic              rdy;
    logic [DUTY_W-1:0] rd;
  } result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [MODE_W-1:0]     s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [FREQ_W-1:0]     cfg_data_i    = '0;

  pulse_duty_bit_capture u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // decoder state as the testbench sees it
  logic [FREQ_W-1:0] band_low     = '0;
  logic [FREQ_W-1:0] band_high    = MICRO_PER_SEC;
  logic [TIME_W-1:0] last_fall_us = '0;
  logic [TIME_W-1:0] last_rise_us = '0;
  logic [CNT_W-1:0]  slot_count   = '0;
  logic              frame_rdy    = 1'b0;
  logic [DUTY_W-1:0] duty_mem [FRAME_BITS];

  result_t pending_results [$];
  int unsigned fail_count     = 0;
  int unsigned item_total     = 0;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;
  int unsigned per_min        = 2;
  int unsigned per_max        = 3000;

  initial begin
    for (int i = 0; i < FRAME_BITS; i++) duty_mem[i] = '0;
  end

  // expected result of one word, advancing the decoder state
  function automatic result_t decode_word(mode_e m, logic [TIME_W-1:0] t,
                                          logic [RIDX_W-1:0] idx, logic clr);
    result_t           r;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] high_t;
    logic [63:0]       quot;
    logic              outside;
    r = '0;
    outside = 1'b0;
    case (m)
      MODE_RISE: begin
        last_rise_us = t;
      end
      MODE_FALL: begin
        period = t - last_fall_us;
        high_t = t - last_rise_us;
        last_fall_us = t;
        if (period == 0) begin
          r.freq  = MICRO_PER_SEC;
          r.duty  = DUTY_MAX;
          outside = 1'b1;
        end else begin
          r.freq = FREQ_W'(32'd1000000 / period);
          if (high_t >= period) begin
            r.duty = DUTY_MAX;
          end else begin
            quot   = ({32'd0, high_t} << DUTY_FRAC_BITS) / {32'd0, period};
            r.duty = quot[DUTY_W-1:0];
          end
          outside = (64'd5 * high_t > 64'd3 * period) || (64'd5 * high_t < 64'd2 * period);
        end
        r.band = (r.freq > band_low) && (r.freq < band_high);
        // a ready frame freezes the store and the count
        if (!frame_rdy) begin
          if (r.band) begin
            if (outside && slot_count < FRAME_BITS) begin
              duty_mem[slot_count[STORE_W-1:0]] = r.duty;
              slot_count = slot_count + 1'b1;
              r.cap = 1'b1;
            end
          end else begin
            if (slot_count >= FRAME_BITS) frame_rdy = 1'b1;
            slot_count = '0;
          end
        end
      end
      MODE_READ: begin
        r.rd = duty_mem[idx];
      end
      default: begin
      end
    endcase
    r.rdy = frame_rdy;
    if (m == MODE_READ && clr) frame_rdy = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 100) $display("mismatch: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // result checker, sampled on the falling clock edge before the accepting edge
  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("frequency_hz", 32'(m_axis_tdata[19:0]), 32'(want.freq));
        check_field("duty_q16", 32'(m_axis_tdata[35:20]), 32'(want.duty));
        check_field("in_band", 32'(m_axis_tdata[36]), 32'(want.band));
        check_field("captured", 32'(m_axis_tdata[37]), 32'(want.cap));
        check_field("frame_ready", 32'(m_axis_tdata[38]), 32'(want.rdy));
        check_field("read_duty_q16", 32'(m_axis_tdata[54:39]), 32'(want.rd));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // send one input word and record its expected result
  task automatic send_word(input mode_e m, input logic [TIME_W-1:0] t,
                           input logic [RIDX_W-1:0] idx, input logic clr);
    logic ok;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= m;
    s_axis_tdata  <= IN_DATA_W'({clr, idx, t});
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      @(posedge clk_i);
    end while (!ok);
    pending_results.push_back(decode_word(m, t, idx, clr));
    item_total++;
  endtask

  // sender pauses until every result is back and the block has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e r, input logic [FREQ_W-1:0] v);
    logic ok;
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= r;
    cfg_data_i  <= v;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    if (r == REG_FREQ_LOW) band_low = v;
    else band_high = v;
  endtask

  task automatic set_band(input logic [FREQ_W-1:0] lo, input logic [FREQ_W-1:0] hi,
                          input int unsigned pmin, input int unsigned pmax);
    write_reg(REG_FREQ_LOW, lo);
    write_reg(REG_FREQ_HIGH, hi);
    per_min = pmin;
    per_max = pmax;
  endtask

  // band around a random range of periods
  task automatic set_random_band();
    int unsigned pmin;
    int unsigned pmax;
    int          lo;
    int unsigned hi;
    pmin = $urandom_range(2, 200);
    pmax = pmin + $urandom_range(0, 2000);
    lo   = 1000000 / pmax - 1 - $urandom_range(0, 300);
    if (lo < 0) lo = 0;
    hi   = 1000000 / pmin + 1 + $urandom_range(0, 300);
    set_band(FREQ_W'(lo), FREQ_W'(hi), pmin, pmax);
  endtask

  task automatic set_idle_profile(input int unsigned src, input int unsigned sink);
    src_idle_pct   = src;
    sink_stall_pct <= sink;
  endtask

  // rising edge then falling edge with the given period and high time
  task automatic send_pulse(input logic [TIME_W-1:0] p, input logic [TIME_W-1:0] h);
    logic [TIME_W-1:0] fall_at;
    fall_at = last_fall_us + p;
    send_word(MODE_RISE, fall_at - h, RIDX_W'($urandom), 1'($urandom_range(0, 1)));
    send_word(MODE_FALL, fall_at, RIDX_W'($urandom), 1'($urandom_range(0, 1)));
  endtask

  // zero, one-microsecond or very long period: never in band
  task automatic send_gap_pulse();
    case ($urandom_range(0, 2))
      0: send_pulse(0, $urandom_range(0, 50));
      1: send_pulse(1, $urandom_range(0, 1));
      default: send_pulse(2000000 + $urandom_range(0, 32'h7fff_ffff), $urandom_range(0, 5000));
    endcase
  endtask

  // pulse with a period in the current range, duty outside the middle band unless mid is set
  task automatic send_band_pulse(input bit mid);
    int unsigned p;
    int unsigned lo;
    int unsigned hi;
    p  = $urandom_range(per_min, per_max);
    lo = (2 * p + 4) / 5;
    hi = (3 * p) / 5;
    if (mid && lo <= hi) send_pulse(p, $urandom_range(lo, hi));
    else if ($urandom_range(0, 1)) send_pulse(p, $urandom_range(0, (2 * p - 1) / 5));
    else send_pulse(p, $urandom_range(3 * p / 5 + 1, p + 10));
  endtask

  task automatic send_read(input bit clr);
    send_word(MODE_READ, $urandom, RIDX_W'($urandom_range(0, 7)), clr);
  endtask

  // gap, a run of pulses, optionally a closing gap, host reads, maybe a pulse, then a clearing read
  task automatic run_frame(input int unsigned n_pulses, input bit close,
                           input int unsigned n_reads);
    send_gap_pulse();
    repeat (n_pulses) send_band_pulse($urandom_range(0, 9) == 0);
    if (close) send_gap_pulse();
    repeat (n_reads) send_read($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 3) == 0) send_band_pulse(1'b0);
    send_read(1'b1);
  endtask

  task automatic send_noise();
    send_word(mode_e'($urandom_range(0, 3)), $urandom, RIDX_W'($urandom_range(0, 7)),
              1'($urandom_range(0, 1)));
  endtask

  // field extremes, thresholds, saturation and wrap
  task automatic test_directed_edges();
    send_word(MODE_READ, 32'd0, 3'd0, 1'b0);
    send_word(MODE_NONE, 32'hffff_ffff, 3'd7, 1'b1);
    send_word(MODE_FALL, 32'd0, 3'd0, 1'b0);
    send_word(MODE_RISE, 32'd100, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'd150, 3'd0, 1'b0);
    send_word(MODE_RISE, 32'd100, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'd300, 3'd0, 1'b0);
    // duty exactly 0.4, then exactly 0.6
    send_word(MODE_RISE, 32'd306, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'd310, 3'd0, 1'b0);
    send_word(MODE_RISE, 32'd314, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'd320, 3'd0, 1'b0);
    send_word(MODE_RISE, 32'd321, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'd330, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'd331, 3'd0, 1'b0);
    // timestamps wrapping through zero
    send_word(MODE_RISE, 32'hffff_fff0, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'h0000_0010, 3'd0, 1'b0);
    send_word(MODE_RISE, 32'h0000_0030, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'h0000_0040, 3'd0, 1'b0);
    send_word(MODE_READ, 32'd0, 3'd1, 1'b0);
    send_word(MODE_RISE, 32'hffff_ffff, 3'd0, 1'b0);
    send_word(MODE_FALL, 32'h0000_0005, 3'd0, 1'b0);
    send_word(MODE_READ, 32'hffff_ffff, 3'd7, 1'b1);
    wait_drained();
  endtask

  // complete frames, an over-full buffer and a short frame
  task automatic test_full_frames();
    run_frame(8, 1'b1, 0);
    for (int i = 0; i < FRAME_BITS; i++) send_word(MODE_READ, $urandom, RIDX_W'(i), 1'b0);
    send_band_pulse(1'b0);
    send_gap_pulse();
    send_word(MODE_READ, $urandom, 3'd7, 1'b1);
    run_frame(11, 1'b1, 3);
    run_frame(5, 1'b1, 2);
    wait_drained();
  endtask

  // long receiver hold-off while words keep coming
  task automatic test_backpressure();
    set_idle_profile(0, 0);
    hold_seq <= hold_seq + 1;
    repeat (30) send_noise();
    run_frame(9, 1'b1, 4);
    wait_drained();
  endtask

  // several band settings and idle profiles, mostly frames with random content
  task automatic test_random_phases();
    int unsigned stop_at;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_band(FREQ_W'(0), MICRO_PER_SEC, 2, 3000);
        1: set_band(FREQ_W'(1000), FREQ_W'(50000), 21, 999);
        3: set_band(MICRO_PER_SEC, FREQ_W'(0), 2, 3000);
        5: set_band(FREQ_W'(0), MICRO_PER_SEC, 2, 1000);
        7: set_band(FREQ_W'(999999), MICRO_PER_SEC, 2, 3000);
        default: set_random_band();
      endcase
      case (ph % 4)
        0: set_idle_profile(0, 0);
        1: set_idle_profile(47, 0);
        2: set_idle_profile(0, 47);
        default: set_idle_profile(28, 28);
      endcase
      stop_at = item_total + PHASE_ITEMS;
      while (item_total < stop_at) begin
        if ($urandom_range(0, 9) < 7)
          run_frame($urandom_range(5, 11), $urandom_range(0, 5) != 0, $urandom_range(0, 4));
        else
          repeat ($urandom_range(1, 6)) send_noise();
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_edges();
    test_full_frames();
    test_backpressure();
    test_random_phases();
    set_idle_profile(0, 0);
    wait_drained();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_UNITS;
    $display("tb: failure");
    $finish;
  end

endmodule
